// ===== src/dlts_pkg.sv =====
// Shared types and codes of the delta list task scheduler.
`timescale 1ns / 1ps
package dlts_pkg;

    localparam int MAX_WORKERS_DEF   = 8;
    localparam int PENDING_DEPTH_DEF = 16;
    // List position field of a cell command; wide enough for any worker count up to 128
    localparam int CELL_POS_W        = 7;

    localparam logic [1:0] OP_PUSH    = 2'd0;
    localparam logic [1:0] OP_POP     = 2'd1;
    localparam logic [1:0] OP_ADVANCE = 2'd2;

    localparam logic [2:0] ST_ACTIVE   = 3'd0;
    localparam logic [2:0] ST_PENDING  = 3'd1;
    localparam logic [2:0] ST_POPPED   = 3'd2;
    localparam logic [2:0] ST_ADVANCED = 3'd3;
    localparam logic [2:0] ST_EMPTY    = 3'd4;
    localparam logic [2:0] ST_TOO_BIG  = 3'd5;
    localparam logic [2:0] ST_FULL     = 3'd6;

    localparam logic [1:0] CFG_NUM_WORKERS = 2'd0;
    localparam logic [1:0] CFG_MEM_TOTAL   = 2'd1;

    typedef struct packed {
        logic [31:0] delta;
        logic [31:0] ident;
        logic [31:0] mem;
    } entry_t;

    typedef struct packed {
        logic [31:0] ident;
        logic [31:0] mem;
        logic [31:0] ops;
    } pend_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_POP,
        CELL_ADV
    } cell_op_t;

    typedef struct packed {
        cell_op_t              op;
        logic [CELL_POS_W-1:0] pos;
        logic [31:0]           value;
        logic [31:0]           ident;
        logic [31:0]           mem;
    } cell_cmd_t;

endpackage

// ===== src/delta_list_task_scheduler.sv =====
// Top level of the delta list task scheduler.
`timescale 1ns / 1ps
// Usage:
//   Items arrive on the s_ stream (push, pop or advance) and each produces
//   exactly one result transfer on the m_ stream. s_tready is high only
//   while the sequencer is idle; one item is worked on at a time.
//   Active tasks live in a row of MAX_WORKERS list cells. A pop shifts the
//   whole row toward the front; an insert shifts the cells behind the insert
//   point away from the front. Pending tasks sit in a PENDING_DEPTH deep
//   memory with a registered read port. Advance, rejects and pending pushes
//   go straight to the result. An admitted push walks the list one cell a
//   cycle, then inserts. A pop takes the front, then for each admitted
//   pending task fetches, checks, walks and inserts, plus a final head
//   check when tasks stay pending.
//   The result sits in an output register; the next item is accepted while
//   it waits. The sequencer holds its finished result only when the output
//   register is still occupied.
//   Reset (aresetn low, synchronous) clears counts, memory use and the
//   output valid and sets num_workers to 1 and mem_total to all ones; list
//   cells and pending storage are left as they are. Configuration writes on
//   cfg_we are taken at any edge outside reset and are meant for idle periods only.
module delta_list_task_scheduler
    import dlts_pkg::*;
#(
    parameter int MAX_WORKERS   = MAX_WORKERS_DEF,
    parameter int PENDING_DEPTH = PENDING_DEPTH_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[1:0], task_id[33:2], memory_need[65:34], ops_need[97:66],
    // elapsed_ops[129:98], zero fill up to 136
    input  logic [135:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[2:0], popped_id[34:3], popped_memory[66:35], front_residual[98:67],
    // active_tasks[102:99], pending_tasks[107:103], mem_free[139:108], zero fill
    output logic [143:0] m_tdata
);

    localparam int CW = $clog2(MAX_WORKERS + 1);
    localparam int IW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int PW = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
    localparam int PCW = $clog2(PENDING_DEPTH + 1);

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_WALK   = 6'b000010,
        S_INSERT = 6'b000100,
        S_ADMIT  = 6'b001000,
        S_CHECK  = 6'b010000,
        S_OUT    = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [3:0]  num_workers_reg;
    logic [31:0] mem_total_reg;

    logic [CW-1:0]  act_count_reg, act_count_next;
    logic [PW-1:0]  pend_head_reg, pend_head_next;
    logic [PCW-1:0] pend_count_reg, pend_count_next;
    logic [31:0]    mem_used_reg, mem_used_next;

    logic [2:0]  status_reg, status_next;
    logic [31:0] pid_reg, pid_next;
    logic [31:0] pmem_reg, pmem_next;

    // task being placed into the list
    logic [31:0] new_id_reg, new_id_next;
    logic [31:0] new_mem_reg, new_mem_next;
    logic [31:0] new_ops_reg, new_ops_next;
    logic        from_pop_reg, from_pop_next;
    logic [CW-1:0] pos_reg, pos_next;
    logic [32:0]   sum_reg, sum_next;

    logic         m_valid_reg;
    logic [143:0] m_data_reg;

    // input fields
    logic [1:0]  in_op;
    logic [31:0] in_id, in_need, in_ops, in_elapsed;
    assign in_op      = s_tdata[1:0];
    assign in_id      = s_tdata[33:2];
    assign in_need    = s_tdata[65:34];
    assign in_ops     = s_tdata[97:66];
    assign in_elapsed = s_tdata[129:98];

    logic s_fire;
    assign s_tready = (state_reg == S_IDLE);
    assign s_fire   = s_tvalid && s_tready;

    // cell row
    cell_cmd_t cmd;
    entry_t    cells [MAX_WORKERS];
    entry_t    blank;
    assign blank = '0;

    for (genvar g = 0; g < MAX_WORKERS; g++) begin : g_cell
        dlts_cell #(.IDX(g)) u_cell (
            .aclk      (aclk),
            .cmd       (cmd),
            .left_in   ((g == 0) ? blank : cells[(g == 0) ? 0 : g - 1]),
            .right_in  ((g == MAX_WORKERS - 1) ? cells[g] :
                        cells[(g == MAX_WORKERS - 1) ? g : g + 1]),
            .entry_out (cells[g])
        );
    end

    // pending storage
    logic          fifo_we, fifo_re;
    logic [PW-1:0] fifo_waddr;
    pend_t         fifo_wdata, fifo_rdata;
    logic [PW:0]   slot_sum;

    assign slot_sum   = {1'b0, pend_head_reg} + (PW + 1)'(pend_count_reg);
    assign fifo_waddr = (slot_sum >= (PW + 1)'(PENDING_DEPTH)) ?
                        PW'(slot_sum - (PW + 1)'(PENDING_DEPTH)) : PW'(slot_sum);
    assign fifo_wdata = '{ident: in_id, mem: in_need, ops: in_ops};

    dlts_fifo_mem #(.DEPTH(PENDING_DEPTH), .AW(PW)) u_fifo (
        .aclk    (aclk),
        .wr_en   (fifo_we),
        .wr_addr (fifo_waddr),
        .wr_data (fifo_wdata),
        .rd_en   (fifo_re),
        .rd_addr (pend_head_reg),
        .rd_data (fifo_rdata)
    );

    // worker limit and free memory
    logic [31:0]   nw_wide;
    logic [CW-1:0] worker_limit;
    logic [31:0]   mem_free;
    logic          worker_free;

    assign nw_wide = 32'(num_workers_reg);
    assign worker_limit = (nw_wide == 32'd0) ? CW'(1) :
                          (nw_wide > 32'(MAX_WORKERS)) ? CW'(MAX_WORKERS) : CW'(nw_wide);
    assign mem_free    = (mem_total_reg > mem_used_reg) ? mem_total_reg - mem_used_reg : 32'd0;
    assign worker_free = act_count_reg < worker_limit;

    // walk compare: delta of the cell at the current position
    logic [31:0] walk_delta;
    logic [32:0] walk_sum;
    logic        walk_step;
    assign walk_delta = cells[pos_reg[IW-1:0]].delta;
    assign walk_sum   = sum_reg + {1'b0, walk_delta};
    assign walk_step  = (pos_reg < act_count_reg) && (walk_sum <= {1'b0, new_ops_reg});

    logic [PW-1:0] head_inc;
    assign head_inc = (pend_head_reg == PW'(PENDING_DEPTH - 1)) ? '0 : pend_head_reg + 1'b1;

    always_comb begin
        state_next      = state_reg;
        act_count_next  = act_count_reg;
        pend_head_next  = pend_head_reg;
        pend_count_next = pend_count_reg;
        mem_used_next   = mem_used_reg;
        status_next     = status_reg;
        pid_next        = pid_reg;
        pmem_next       = pmem_reg;
        new_id_next     = new_id_reg;
        new_mem_next    = new_mem_reg;
        new_ops_next    = new_ops_reg;
        from_pop_next   = from_pop_reg;
        pos_next        = pos_reg;
        sum_next        = sum_reg;
        fifo_we         = 1'b0;
        fifo_re         = 1'b0;
        cmd             = '{op: CELL_HOLD, pos: '0, value: '0, ident: '0, mem: '0};

        case (state_reg)
            S_IDLE: begin
                if (s_fire) begin
                    pid_next   = '0;
                    pmem_next  = '0;
                    state_next = S_OUT;
                    case (in_op)
                        OP_PUSH: begin
                            if (in_need > mem_total_reg) begin
                                status_next = ST_TOO_BIG;
                            end else if (worker_free && mem_free >= in_need) begin
                                status_next   = ST_ACTIVE;
                                new_id_next   = in_id;
                                new_mem_next  = in_need;
                                new_ops_next  = in_ops;
                                from_pop_next = 1'b0;
                                pos_next      = '0;
                                sum_next      = '0;
                                state_next    = S_WALK;
                            end else if (pend_count_reg >= PCW'(PENDING_DEPTH)) begin
                                status_next = ST_FULL;
                            end else begin
                                fifo_we         = 1'b1;
                                pend_count_next = pend_count_reg + 1'b1;
                                status_next     = ST_PENDING;
                            end
                        end
                        OP_POP: begin
                            if (act_count_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else begin
                                // take the front and shift the row toward it
                                pid_next       = cells[0].ident;
                                pmem_next      = cells[0].mem;
                                cmd.op         = CELL_POP;
                                act_count_next = act_count_reg - 1'b1;
                                mem_used_next  = mem_used_reg - cells[0].mem;
                                status_next    = ST_POPPED;
                                state_next     = S_ADMIT;
                            end
                        end
                        OP_ADVANCE: begin
                            if (act_count_reg != '0) begin
                                cmd.op    = CELL_ADV;
                                cmd.value = in_elapsed;
                            end
                            status_next = ST_ADVANCED;
                        end
                        default: begin
                            status_next = ST_ADVANCED;
                        end
                    endcase
                end
            end
            S_WALK: begin
                if (walk_step) begin
                    sum_next = walk_sum;
                    pos_next = pos_reg + 1'b1;
                end else begin
                    state_next = S_INSERT;
                end
            end
            S_INSERT: begin
                cmd.op         = CELL_INSERT;
                cmd.pos        = CELL_POS_W'(pos_reg);
                cmd.value      = new_ops_reg - sum_reg[31:0];
                cmd.ident      = new_id_reg;
                cmd.mem        = new_mem_reg;
                act_count_next = act_count_reg + 1'b1;
                mem_used_next  = mem_used_reg + new_mem_reg;
                if (from_pop_reg) begin
                    pend_head_next  = head_inc;
                    pend_count_next = pend_count_reg - 1'b1;
                    state_next      = S_ADMIT;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_ADMIT: begin
                if (pend_count_reg != '0) begin
                    fifo_re    = 1'b1;
                    state_next = S_CHECK;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_CHECK: begin
                if (worker_free && mem_free >= fifo_rdata.mem) begin
                    new_id_next   = fifo_rdata.ident;
                    new_mem_next  = fifo_rdata.mem;
                    new_ops_next  = fifo_rdata.ops;
                    from_pop_next = 1'b1;
                    pos_next      = '0;
                    sum_next      = '0;
                    state_next    = S_WALK;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            num_workers_reg <= 4'd1;
            mem_total_reg   <= 32'hFFFF_FFFF;
            act_count_reg   <= '0;
            pend_head_reg   <= '0;
            pend_count_reg  <= '0;
            mem_used_reg    <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg      <= state_next;
            act_count_reg  <= act_count_next;
            pend_head_reg  <= pend_head_next;
            pend_count_reg <= pend_count_next;
            mem_used_reg   <= mem_used_next;
            if (cfg_we) begin
                case (cfg_index)
                    CFG_NUM_WORKERS: num_workers_reg <= cfg_data[3:0];
                    CFG_MEM_TOTAL:   mem_total_reg   <= cfg_data;
                    default:         ;
                endcase
            end
            // load the result when the output register is free, drop it on transfer
            if (state_reg == S_OUT && (!m_valid_reg || m_tready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        status_reg   <= status_next;
        pid_reg      <= pid_next;
        pmem_reg     <= pmem_next;
        new_id_reg   <= new_id_next;
        new_mem_reg  <= new_mem_next;
        new_ops_reg  <= new_ops_next;
        from_pop_reg <= from_pop_next;
        pos_reg      <= pos_next;
        sum_reg      <= sum_next;
        if (state_reg == S_OUT && (!m_valid_reg || m_tready)) begin
            m_data_reg <= {4'd0,
                           mem_free,
                           5'(pend_count_reg),
                           4'(act_count_reg),
                           (act_count_reg != '0) ? cells[0].delta : 32'd0,
                           pmem_reg,
                           pid_reg,
                           status_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// ===== src/dlts_cell.sv =====
// One entry of the active delta list.
`timescale 1ns / 1ps
module dlts_cell
    import dlts_pkg::*;
#(
    parameter int IDX = 0
) (
    input  logic      aclk,
    input  cell_cmd_t cmd,
    input  entry_t    left_in,
    input  entry_t    right_in,
    output entry_t    entry_out
);

    localparam logic [CELL_POS_W:0] MY_IDX = (CELL_POS_W + 1)'(IDX);

    entry_t entry_reg;
    entry_t entry_next;
    logic [CELL_POS_W:0] pos_w;

    assign pos_w = {1'b0, cmd.pos};

    always_comb begin
        entry_next = entry_reg;
        case (cmd.op)
            CELL_INSERT: begin
                if (MY_IDX > pos_w) begin
                    entry_next = left_in;
                    // the entry pushed back loses the new entry's delta
                    if (MY_IDX == pos_w + 1'b1) begin
                        entry_next.delta = left_in.delta - cmd.value;
                    end
                end else if (MY_IDX == pos_w) begin
                    entry_next.delta = cmd.value;
                    entry_next.ident = cmd.ident;
                    entry_next.mem   = cmd.mem;
                end
            end
            CELL_POP: begin
                entry_next = right_in;
            end
            CELL_ADV: begin
                if (MY_IDX == '0) begin
                    entry_next.delta = (cmd.value < entry_reg.delta) ?
                                       entry_reg.delta - cmd.value : 32'd0;
                end
            end
            default: begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        entry_reg <= entry_next;
    end

    assign entry_out = entry_reg;

endmodule

// ===== src/dlts_fifo_mem.sv =====
// Storage of the pending task FIFO, registered read.
`timescale 1ns / 1ps
module dlts_fifo_mem
    import dlts_pkg::*;
#(
    parameter int DEPTH = PENDING_DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  pend_t         wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output pend_t         rd_data
);

    pend_t mem_reg [DEPTH];
    pend_t rd_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_reg;

endmodule

// ===== verif/delta_list_task_scheduler_tb.sv =====
// Self-checking testbench for the delta list task scheduler.
`timescale 1ns / 1ps
module delta_list_task_scheduler_tb
    import dlts_pkg::*;
();

    localparam int NW = 8;
    localparam int PD = 16;
    localparam int RANDOM_ITEMS = 850;
    localparam longint CYCLE_LIMIT = 2000000;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [31:0]  cfg_data = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // operation, task_id, memory_need, ops_need, elapsed_ops, zero fill
    logic [135:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // status, popped_id, popped_memory, front_residual, active_tasks,
    // pending_tasks, mem_free, zero fill
    logic [143:0] m_tdata;

    typedef struct packed {
        logic [31:0] elapsed;
        logic [31:0] ops;
        logic [31:0] need;
        logic [31:0] ident;
        logic [1:0]  op;
    } job_t;

    typedef struct packed {
        logic [31:0] mem_free;
        logic [4:0]  pend_n;
        logic [3:0]  act_n;
        logic [31:0] front;
        logic [31:0] pmem;
        logic [31:0] pid;
        logic [2:0]  status;
    } sched_out_t;

    // directed row: stimulus plus an optional typed-in expectation
    typedef struct {
        job_t       job;
        bit         fixed;
        sched_out_t want;
    } row_t;

    delta_list_task_scheduler DUT (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always #5 aclk = ~aclk;

    // scheduler shadow state
    logic [31:0] workers_cfg, budget;
    logic [31:0] act_delta [NW], act_id [NW], act_mem [NW];
    int unsigned act_n;
    logic [31:0] pq_id [PD], pq_mem [PD], pq_ops [PD];
    int unsigned pq_head, pq_n;
    logic [31:0] mem_used;

    sched_out_t sched_expected [$];
    int errors = 0;
    longint cycles = 0;

    function automatic int unsigned worker_cap();
        if (workers_cfg == 0) return 1;
        if (workers_cfg > NW) return NW;
        return workers_cfg;
    endfunction

    function automatic logic [31:0] budget_left();
        return (budget > mem_used) ? budget - mem_used : 32'd0;
    endfunction

    function automatic bit fits(logic [31:0] need);
        return act_n < worker_cap() && budget_left() >= need;
    endfunction

    // place a task into the sorted delta list
    function automatic void list_insert(logic [31:0] id, logic [31:0] m, logic [31:0] ops);
        int unsigned pos;
        logic [63:0] acc;
        logic [31:0] d;
        pos = 0;
        acc = 0;
        while (pos < act_n && acc + act_delta[pos] <= ops) begin
            acc += act_delta[pos];
            pos++;
        end
        d = ops - acc[31:0];
        if (pos < act_n) act_delta[pos] -= d;
        for (int k = act_n; k > pos; k--) begin
            act_delta[k] = act_delta[k-1];
            act_id[k] = act_id[k-1];
            act_mem[k] = act_mem[k-1];
        end
        act_delta[pos] = d;
        act_id[pos] = id;
        act_mem[pos] = m;
        act_n++;
        mem_used += m;
    endfunction

    function automatic sched_out_t schedule_step(job_t j);
        sched_out_t r;
        r = '0;
        r.status = ST_ADVANCED;
        case (j.op)
            OP_PUSH: begin
                if (j.need > budget) r.status = ST_TOO_BIG;
                else if (fits(j.need)) begin
                    list_insert(j.ident, j.need, j.ops);
                    r.status = ST_ACTIVE;
                end else if (pq_n >= PD) r.status = ST_FULL;
                else begin
                    int unsigned s;
                    s = (pq_head + pq_n) % PD;
                    pq_id[s] = j.ident;
                    pq_mem[s] = j.need;
                    pq_ops[s] = j.ops;
                    pq_n++;
                    r.status = ST_PENDING;
                end
            end
            OP_POP: begin
                if (act_n == 0) r.status = ST_EMPTY;
                else begin
                    r.pid = act_id[0];
                    r.pmem = act_mem[0];
                    for (int k = 1; k < act_n; k++) begin
                        act_delta[k-1] = act_delta[k];
                        act_id[k-1] = act_id[k];
                        act_mem[k-1] = act_mem[k];
                    end
                    act_n--;
                    mem_used -= r.pmem;
                    while (pq_n > 0 && fits(pq_mem[pq_head])) begin
                        list_insert(pq_id[pq_head], pq_mem[pq_head], pq_ops[pq_head]);
                        pq_head = (pq_head + 1) % PD;
                        pq_n--;
                    end
                    r.status = ST_POPPED;
                end
            end
            OP_ADVANCE: begin
                if (act_n > 0)
                    act_delta[0] -= (j.elapsed < act_delta[0]) ? j.elapsed : act_delta[0];
            end
            default: ;
        endcase
        r.front = (act_n > 0) ? act_delta[0] : 32'd0;
        r.act_n = act_n[3:0];
        r.pend_n = pq_n[4:0];
        r.mem_free = budget_left();
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
        errors++;
    endtask

    // short gaps mostly, an occasional long one, and runs with none
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random stalls, check each transfer at the rising edge
    always @(negedge aclk) begin
        if (aresetn && $urandom_range(0, 3) != 0) m_tready <= 1'b1;
        else if (aresetn && $urandom_range(0, 19) == 0) m_tready <= 1'b0;
        else m_tready <= (aresetn && $urandom_range(0, 1) == 0) ? 1'b1 : 1'b0;
    end

    always @(posedge aclk) begin
        sched_out_t got, want;
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("delta_list_task_scheduler_tb: done, errors");
            $finish;
        end else if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata[$bits(sched_out_t)-1:0];
            if (sched_expected.size() == 0) begin
                $display("%0t: unexpected result transfer", $realtime);
                errors++;
            end else begin
                want = sched_expected[0];
                sched_expected.delete(0);
                if (got.status !== want.status) report_mismatch("status", got.status, want.status);
                if (got.pid !== want.pid) report_mismatch("popped_id", got.pid, want.pid);
                if (got.pmem !== want.pmem) report_mismatch("popped_memory", got.pmem, want.pmem);
                if (got.front !== want.front) report_mismatch("front_residual", got.front, want.front);
                if (got.act_n !== want.act_n) report_mismatch("active_tasks", got.act_n, want.act_n);
                if (got.pend_n !== want.pend_n) report_mismatch("pending_tasks", got.pend_n, want.pend_n);
                if (got.mem_free !== want.mem_free) report_mismatch("mem_free", got.mem_free, want.mem_free);
            end
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [31:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
        if (idx == CFG_NUM_WORKERS) workers_cfg = val & 32'hF;
        else budget = val;
    endtask

    // drop valid, wait until every expected result is in, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (sched_expected.size() != 0) @(negedge aclk);
        repeat (8 * NW + 20) @(negedge aclk);
    endtask

    // hand one item over; the prediction is queued at the transfer edge.
    // Valid stays high after the transfer so a zero gap follows directly.
    task automatic send(job_t j, bit fixed, sched_out_t want);
        sched_out_t p;
        int g;
        g = gap_len();
        if (g != 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, j};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        p = schedule_step(j);
        if (fixed && p !== want) begin
            $display("%0t: directed row disagrees with predictor", $realtime);
            errors++;
        end
        sched_expected.push_back(p);
        @(negedge aclk);
    endtask

    function automatic job_t mk(logic [1:0] op, logic [31:0] id, logic [31:0] need,
                                logic [31:0] ops, logic [31:0] el);
        job_t j;
        j.op = op; j.ident = id; j.need = need; j.ops = ops; j.elapsed = el;
        return j;
    endfunction

    function automatic sched_out_t mk_out(logic [2:0] st, logic [31:0] front,
                                          logic [3:0] a, logic [4:0] p, logic [31:0] mf);
        sched_out_t r;
        r = '0;
        r.status = st; r.front = front; r.act_n = a; r.pend_n = p; r.mem_free = mf;
        return r;
    endfunction

    // random item of any operation, its memory size at times matched to the current budget
    function automatic job_t rand_job();
        job_t j;
        int r;
        j = {$urandom, $urandom, $urandom, $urandom, 2'($urandom)};
        r = $urandom_range(0, 99);
        if (r < 45) j.op = OP_PUSH;
        else if (r < 80) j.op = OP_POP;
        else if (r < 97) j.op = OP_ADVANCE;
        else j.op = 2'd3;
        case ($urandom_range(0, 3))
            0: j.need = 0;
            1: j.need = $urandom_range(0, 300);
            2: j.need = budget == 0 ? 32'd0 : $urandom_range(0, budget);
            default: ;
        endcase
        if ($urandom_range(0, 2) == 0) j.ops = $urandom_range(0, 1000);
        if ($urandom_range(0, 1) == 0) j.elapsed = $urandom_range(0, 500);
        return j;
    endfunction

    row_t rows [$];

    initial begin
        logic [31:0] cfg_w [6];
        logic [31:0] cfg_m [6];
        workers_cfg = 1;
        budget = 32'hFFFF_FFFF;
        act_n = 0; pq_head = 0; pq_n = 0; mem_used = 0;
        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;

        // after reset: empty errors, one worker, whole budget free
        rows.push_back('{mk(OP_POP, 0, 0, 0, 0), 1,
                         mk_out(ST_EMPTY, 0, 0, 0, 32'hFFFF_FFFF)});
        rows.push_back('{mk(OP_ADVANCE, 0, 0, 0, 32'hFFFF_FFFF), 1,
                         mk_out(ST_ADVANCED, 0, 0, 0, 32'hFFFF_FFFF)});
        rows.push_back('{mk(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                            32'hFFFF_FFFF), 1, mk_out(ST_ADVANCED, 0, 0, 0, 32'hFFFF_FFFF)});
        rows.push_back('{mk(OP_PUSH, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0), 1,
                         mk_out(ST_ACTIVE, 32'hFFFF_FFFF, 1, 0, 0)});
        rows.push_back('{mk(OP_PUSH, 7, 0, 5, 0), 1, mk_out(ST_PENDING, 32'hFFFF_FFFF, 1, 1, 0)});
        rows.push_back('{mk(OP_ADVANCE, 0, 0, 0, 10), 0, '0});
        rows.push_back('{mk(OP_POP, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk(OP_ADVANCE, 0, 0, 0, 32'hFFFF_FFFF), 0, '0});
        rows.push_back('{mk(OP_POP, 0, 0, 0, 0), 0, '0});
        foreach (rows[i]) send(rows[i].job, rows[i].fixed, rows[i].want);
        drain();

        // more workers, small budget: ordering, oversize, full queue
        write_reg(CFG_NUM_WORKERS, 3);
        write_reg(CFG_MEM_TOTAL, 100);
        rows.delete();
        rows.push_back('{mk(OP_PUSH, 1, 101, 0, 0), 1, mk_out(ST_TOO_BIG, 0, 0, 0, 100)});
        rows.push_back('{mk(OP_PUSH, 2, 40, 50, 0), 0, '0});
        rows.push_back('{mk(OP_PUSH, 3, 40, 20, 0), 0, '0});
        rows.push_back('{mk(OP_PUSH, 4, 10, 80, 0), 0, '0});
        rows.push_back('{mk(OP_PUSH, 5, 100, 30, 0), 0, '0});
        foreach (rows[i]) send(rows[i].job, rows[i].fixed, rows[i].want);
        for (int i = 0; i < 17; i++) send(mk(OP_PUSH, 100 + i, i, i, 0), 0, '0);
        drain();
        // budget below use; then worker count 0 and above the maximum
        write_reg(CFG_MEM_TOTAL, 0);
        send(mk(OP_PUSH, 9, 0, 0, 0), 0, '0);
        send(mk(OP_POP, 0, 0, 0, 0), 0, '0);
        drain();
        write_reg(CFG_NUM_WORKERS, 0);
        write_reg(CFG_MEM_TOTAL, 32'hFFFF_FFFF);
        send(mk(OP_POP, 0, 0, 0, 0), 0, '0);
        drain();
        write_reg(CFG_NUM_WORKERS, 15);
        for (int i = 0; i < 4; i++) send(mk(OP_POP, 0, 0, 0, 0), 0, '0);
        drain();

        // random phases across several settings, extremes included
        cfg_w = '{8, 1, 15, 4, 0, 2};
        cfg_m = '{32'hFFFF_FFFF, 500, 1000, 0, 200, 32'hFFFF_FFFF};
        for (int ph = 0; ph < 6; ph++) begin
            write_reg(CFG_NUM_WORKERS, cfg_w[ph]);
            write_reg(CFG_MEM_TOTAL, cfg_m[ph]);
            for (int i = 0; i < RANDOM_ITEMS / 6; i++) begin
                send(rand_job(), 0, '0);
                // hold off until the block has answered everything
                if (i == 40) begin
                    s_tvalid <= 1'b0;
                    @(negedge aclk);
                    while (sched_expected.size() != 0) @(negedge aclk);
                end
            end
            drain();
        end

        if (errors == 0) $display("delta_list_task_scheduler_tb: done, clean");
        else $display("delta_list_task_scheduler_tb: done, errors");
        $finish;
    end
endmodule

// ===== sim.f =====
src/dlts_pkg.sv
src/dlts_cell.sv
src/dlts_fifo_mem.sv
src/delta_list_task_scheduler.sv
verif/delta_list_task_scheduler_tb.sv
